// File: design/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types and constants of the merge sort engine: item payloads,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package msort_pkg;

  // Element width, fixed by the item format
  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_result;
    logic                         overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic merge;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sorted;
    logic pass_end;
    logic emit_fire;
    logic emit_last;
  } ctl_status_t;

endpackage

// File: design/msort_ctrl.sv
// ----------------------------------------------------------------------------
// msort_ctrl
// Sequencer of the merge sort engine: load, set up each merge pass, run the
// merge, emit the sorted set and return to loading.
// ----------------------------------------------------------------------------
module msort_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_stall,
  output msort_pkg::ctl_cmd_t   cmd,
  input  msort_pkg::ctl_status_t status
);

  msort_pkg::ctl_state_t state_r;
  msort_pkg::ctl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msort_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      msort_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
        if (in_valid && in_last) begin
          state_nxt = msort_pkg::ST_INIT;
        end
      end
      msort_pkg::ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = msort_pkg::ST_SETUP;
      end
      msort_pkg::ST_SETUP: begin
        // read heads settle here; skip merging once runs cover the set
        if (status.sorted) begin
          state_nxt = msort_pkg::ST_EMIT;
        end else begin
          state_nxt = msort_pkg::ST_MERGE;
        end
      end
      msort_pkg::ST_MERGE: begin
        cmd.merge = 1'b1;
        if (status.pass_end) begin
          state_nxt = msort_pkg::ST_SETUP;
        end
      end
      msort_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_fire && status.emit_last) begin
          state_nxt = msort_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = msort_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// File: design/msort_datapath.sv
// ----------------------------------------------------------------------------
// msort_datapath
// Element and scratch stores, run pointers of the bottom-up merge, the head
// compare and the output register.
// ----------------------------------------------------------------------------
module msort_datapath #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  msort_pkg::in_item_t    in_data,
  input  msort_pkg::ctl_cmd_t    cmd,
  output msort_pkg::ctl_status_t status,
  input  logic                   out_stall,
  output logic                   out_valid,
  output msort_pkg::out_item_t   out_data
);

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int SW = CW + 2;
  localparam int DW = msort_pkg::DATA_WIDTH;

  // Stores: ping-pong between merge passes
  logic [DW-1:0] mem0 [MAX_ELEMENTS];
  logic [DW-1:0] mem1 [MAX_ELEMENTS];
  logic [DW-1:0] rd0_l_r, rd0_r_r, rd1_l_r, rd1_r_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic [CW:0]   w_r, w_nxt;
  logic [CW-1:0] lo_r, lo_nxt, l_r, l_nxt, r_r, r_nxt, k_r, k_nxt;
  logic          src_sel_r, src_sel_nxt;
  logic          out_valid_r;
  msort_pkg::out_item_t out_data_r;

  logic [SW-1:0] n_e, w_e, lo_e, mid_s, mid_e, hi_s, hi_e, nr_s, nr_e, pr_e;
  logic [CW:0]   w2;
  logic signed [DW-1:0] head_l, head_r, merge_val;
  logic          l_in_run, r_in_run, take_left, run_end, pass_end;
  logic          full, emit_fire, emit_last;
  logic          we0, we1;
  logic [IW-1:0] wa0;
  logic [DW-1:0] wd0;

  // Run bounds of the current pair
  always_comb begin
    n_e   = SW'(cnt_r);
    w_e   = SW'(w_r);
    lo_e  = SW'(lo_r);
    mid_s = lo_e + w_e;
    mid_e = (mid_s > n_e) ? n_e : mid_s;
    hi_s  = lo_e + (w_e << 1);
    hi_e  = (hi_s > n_e) ? n_e : hi_s;
    nr_s  = hi_e + w_e;
    nr_e  = (nr_s > n_e) ? n_e : nr_s;
    w2    = w_r << 1;
    pr_e  = (SW'(w2) > n_e) ? n_e : SW'(w2);
  end

  // Head compare: ties go to the right run
  always_comb begin
    head_l    = src_sel_r ? rd1_l_r : rd0_l_r;
    head_r    = src_sel_r ? rd1_r_r : rd0_r_r;
    l_in_run  = SW'(l_r) < mid_e;
    r_in_run  = SW'(r_r) < hi_e;
    take_left = l_in_run && (!r_in_run || (head_l < head_r));
    merge_val = take_left ? head_l : head_r;
    run_end   = (SW'(k_r) + SW'(1)) == hi_e;
    pass_end  = run_end && (hi_e == n_e);
    full      = cnt_r >= CW'(MAX_ELEMENTS);
    emit_fire = cmd.emit && (!out_valid_r || !out_stall);
    emit_last = (SW'(l_r) + SW'(1)) == n_e;
  end

  assign status.sorted    = SW'(w_r) >= n_e;
  assign status.pass_end  = pass_end;
  assign status.emit_fire = emit_fire;
  assign status.emit_last = emit_last;

  // Count and drop flag; clear once the final result is issued
  always_comb begin
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (emit_fire && emit_last) begin
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        drop_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  // Pointer update: start, merge step, run and pass ends, emit advance
  always_comb begin
    w_nxt       = w_r;
    lo_nxt      = lo_r;
    l_nxt       = l_r;
    r_nxt       = r_r;
    k_nxt       = k_r;
    src_sel_nxt = src_sel_r;
    if (cmd.init) begin
      w_nxt       = (CW+1)'(1);
      lo_nxt      = '0;
      l_nxt       = '0;
      k_nxt       = '0;
      r_nxt       = (n_e > SW'(1)) ? CW'(1) : CW'(n_e);
      src_sel_nxt = 1'b0;
    end else if (cmd.merge) begin
      if (pass_end) begin
        w_nxt       = w2;
        lo_nxt      = '0;
        l_nxt       = '0;
        k_nxt       = '0;
        r_nxt       = CW'(pr_e);
        src_sel_nxt = !src_sel_r;
      end else if (run_end) begin
        lo_nxt = CW'(hi_e);
        l_nxt  = CW'(hi_e);
        k_nxt  = CW'(hi_e);
        r_nxt  = CW'(nr_e);
      end else begin
        if (take_left) begin
          l_nxt = l_r + CW'(1);
        end else begin
          r_nxt = r_r + CW'(1);
        end
        k_nxt = k_r + CW'(1);
      end
    end else if (emit_fire) begin
      l_nxt = l_r + CW'(1);
    end
  end

  // Store write ports
  always_comb begin
    we0 = (cmd.load && !full) || (cmd.merge && src_sel_r);
    we1 = cmd.merge && !src_sel_r;
    wa0 = cmd.load ? cnt_r[IW-1:0] : k_r[IW-1:0];
    wd0 = cmd.load ? in_data.value : merge_val;
  end

  // Stores: one write, two registered reads at the next head pointers
  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa0] <= wd0;
    end
    rd0_l_r <= mem0[l_nxt[IW-1:0]];
    rd0_r_r <= mem0[r_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[k_r[IW-1:0]] <= merge_val;
    end
    rd1_l_r <= mem1[l_nxt[IW-1:0]];
    rd1_r_r <= mem1[r_nxt[IW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      w_r         <= '0;
      lo_r        <= '0;
      l_r         <= '0;
      r_r         <= '0;
      k_r         <= '0;
      src_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      w_r       <= w_nxt;
      lo_r      <= lo_nxt;
      l_r       <= l_nxt;
      r_r       <= r_nxt;
      k_r       <= k_nxt;
      src_sel_r <= src_sel_nxt;
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r.sorted_value <= head_l;
      out_data_r.last_result  <= emit_last;
      out_data_r.overflow     <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Collects a set of signed values and returns them in ascending order.
// ----------------------------------------------------------------------------
// Items are taken one per cycle into the element store until the item marked
// last; items beyond MAX_ELEMENTS are dropped and every result of that set
// carries overflow. The set of n elements is then sorted by bottom-up merge
// passes that alternate between the element and scratch stores, one element
// per cycle through the head compare, with a setup state before each pass,
// and finally emitted one element per cycle while the output is not stalled,
// with the final one marked last. The merge loop through the single head
// comparator takes the bulk of the time per set. Input stalls from the last
// item until the final result has been loaded into the output register.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  msort_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output msort_pkg::out_item_t out_data
);

  msort_pkg::ctl_cmd_t    cmd;
  msort_pkg::ctl_status_t status;

  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_item),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  msort_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: design/msort_checker.sv
// ----------------------------------------------------------------------------
// msort_checker
// Port-level checks of the merge sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module msort_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input msort_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input msort_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Close input once a set ends
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_item |=> in_stall)
    else $error("input taken after end of set");

  // Keep input closed while a set is still being emitted
  a_stall_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> in_stall)
    else $error("input open during emit");

  // Advance without gaps inside a set
  a_emit_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_result |=> out_valid)
    else $error("gap in sorted output");

endmodule

bind merge_sort_engine msort_checker u_msort_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
